/* sv/sha256_stream_hasher_core_defines.svh */
// Assertion macros shared by the hasher RTL.
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`ifndef SYNTH
`define SHA_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("implication check failed");
`define SHA_ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define SHA_ASSERT_IMP(lbl, clk, rstn, a, b)
`define SHA_ASSERT_NXT(lbl, clk, rstn, a, b)
`endif
`endif

/* sv/sha_pkg.sv */
// SHA-256 constants, state codes and round functions.
`timescale 1ns / 1ps
package sha_pkg;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPad  = 2'd1;
  localparam logic [1:0] StComp = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_s0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_s1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

/* sv/sha256_stream_hasher_core.sv */
// Streaming SHA-256 hasher: byte intake, padding, compression and digest output.
// Data bytes are accepted only while idle; the 64th byte of a block starts its 64 rounds, during which input stalls.
// Finish: one cycle per pad/length byte up to the block end, 64 rounds per block
// (one or two blocks), then four digest words, one per output transfer.
// Throughput is set by the single round unit reading the 16-word block memory.
// Reset: asynchronous active low; chaining words take the initial hash values,
// counters clear; the block memory holds no reset value and no word is used before it is written.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_core_defines.svh"
module sha256_stream_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);

  logic [1:0]  state_q, state_d;
  logic [5:0]  fill_q;
  logic [63:0] total_q;
  logic [63:0] bits_q;
  logic [23:0] pack_q;
  logic        first_q, wrap_pend_q, final_q, ret_pad_q;
  logic [5:0]  rnd_q;
  logic [1:0]  widx_q;
  logic [31:0] chain_q [8];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] win_q [16];
  logic [31:0] mem [16];
  logic [31:0] rd_q;
  logic [3:0]  raddr;

  logic        in_xfer, out_xfer, byte_en, len_phase, blk_done, rnd_last;
  logic [7:0]  byte_val, pad_val;
  logic [31:0] w_new, w_cur, t1, t2, maj, chf;

  assign in_ready_o    = (state_q == sha_pkg::StIdle);
  assign in_xfer       = in_valid_i && in_ready_o;
  assign out_valid_o   = (state_q == sha_pkg::StOut);
  assign out_xfer      = out_valid_o && out_ready_i;
  assign digest_word_o = {chain_q[{widx_q, 1'b0}], chain_q[{widx_q, 1'b1}]};
  assign word_index_o  = widx_q;
  assign last_word_o   = (widx_q == 2'd3);

  // Select the next byte: input data or the padding stream
  assign len_phase = !first_q && !wrap_pend_q && (fill_q >= sha_pkg::LenPos);
  assign pad_val   = first_q ? sha_pkg::PadByte : (len_phase ? bits_q[63:56] : 8'h00);
  assign byte_en   = (in_xfer && !op_i) || (state_q == sha_pkg::StPad);
  assign byte_val  = (state_q == sha_pkg::StPad) ? pad_val : data_byte_i;
  assign blk_done  = byte_en && (fill_q == 6'd63);

  // Round datapath
  assign w_new = win_q[0] + sha_pkg::sml_s0(win_q[1]) + win_q[9] + sha_pkg::sml_s1(win_q[14]);
  assign w_cur = (rnd_q < 6'd16) ? rd_q : w_new;
  assign chf   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1    = v_q[7] + sha_pkg::big_s1(v_q[4]) + chf + sha_pkg::RoundK[rnd_q] + w_cur;
  assign t2    = sha_pkg::big_s0(v_q[0]) + maj;
  assign rnd_last = (state_q == sha_pkg::StComp) && (rnd_q == 6'd63);

  always_comb begin
    v_d[0] = t1 + t2;
    v_d[1] = v_q[0];
    v_d[2] = v_q[1];
    v_d[3] = v_q[2];
    v_d[4] = v_q[3] + t1;
    v_d[5] = v_q[4];
    v_d[6] = v_q[5];
    v_d[7] = v_q[6];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sha_pkg::StIdle: begin
        if (in_xfer && op_i) state_d = sha_pkg::StPad;
        else if (blk_done) state_d = sha_pkg::StComp;
      end
      sha_pkg::StPad: begin
        if (blk_done) state_d = sha_pkg::StComp;
      end
      sha_pkg::StComp: begin
        if (rnd_q == 6'd63) begin
          if (final_q) state_d = sha_pkg::StOut;
          else if (ret_pad_q) state_d = sha_pkg::StPad;
          else state_d = sha_pkg::StIdle;
        end
      end
      sha_pkg::StOut: begin
        if (out_xfer && last_word_o) state_d = sha_pkg::StIdle;
      end
      default: state_d = sha_pkg::StIdle;
    endcase
  end

  // Register the block word for the next round while the current round runs
  assign raddr = (state_q == sha_pkg::StComp) ? (rnd_q[3:0] + 4'd1) : 4'd0;

  always_ff @(posedge clk_i) begin
    if (byte_en && (fill_q[1:0] == 2'd3)) mem[fill_q[5:2]] <= {pack_q, byte_val};
    rd_q <= mem[raddr];
  end

  // Hold packing, schedule window and working variables
  always_ff @(posedge clk_i) begin
    if (byte_en) pack_q <= {pack_q[15:0], byte_val};
    if (state_q == sha_pkg::StComp) begin
      for (int j = 0; j < 15; j++) win_q[j] <= win_q[j + 1];
      win_q[15] <= w_cur;
      for (int j = 0; j < 8; j++) v_q[j] <= v_d[j];
    end else begin
      for (int j = 0; j < 8; j++) v_q[j] <= chain_q[j];
    end
  end

  // Control and chaining state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha_pkg::StIdle;
      fill_q      <= '0;
      total_q     <= '0;
      bits_q      <= '0;
      first_q     <= 1'b0;
      wrap_pend_q <= 1'b0;
      final_q     <= 1'b0;
      ret_pad_q   <= 1'b0;
      rnd_q       <= '0;
      widx_q      <= '0;
      for (int j = 0; j < 8; j++) chain_q[j] <= sha_pkg::InitH[j];
    end else begin
      state_q <= state_d;
      if (byte_en) fill_q <= fill_q + 6'd1;
      if (in_xfer && !op_i) total_q <= total_q + 64'd1;
      // Latch the bit length and start padding
      if (in_xfer && op_i) begin
        bits_q      <= {total_q[60:0], 3'b000};
        first_q     <= 1'b1;
        wrap_pend_q <= 1'b0;
      end
      if (state_q == sha_pkg::StPad) begin
        first_q <= 1'b0;
        if (fill_q == 6'd63) wrap_pend_q <= 1'b0;
        else if (first_q && (fill_q >= sha_pkg::LenPos)) wrap_pend_q <= 1'b1;
        if (len_phase) bits_q <= {bits_q[55:0], 8'h00};
      end
      if (blk_done) begin
        ret_pad_q <= (state_q == sha_pkg::StPad);
        final_q   <= (state_q == sha_pkg::StPad) && len_phase;
      end
      // Advance rounds and fold the result into the chain
      if (state_q == sha_pkg::StComp) rnd_q <= rnd_q + 6'd1;
      if (rnd_last) begin
        for (int j = 0; j < 8; j++) chain_q[j] <= chain_q[j] + v_d[j];
      end
      // Step through digest words, then restart the hasher
      if (out_xfer) begin
        widx_q <= widx_q + 2'd1;
        if (last_word_o) begin
          for (int j = 0; j < 8; j++) chain_q[j] <= sha_pkg::InitH[j];
          fill_q  <= '0;
          total_q <= '0;
          final_q <= 1'b0;
        end
      end
    end
  end

  `SHA_ASSERT_IMP(a_ready_excl, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `SHA_ASSERT_NXT(a_final_out, clk_i, rst_ni, rnd_last && final_q, out_valid_o && (widx_q == 2'd0))
  `SHA_ASSERT_NXT(a_restart, clk_i, rst_ni, out_xfer && last_word_o, in_ready_o && (fill_q == 6'd0) && (total_q == 64'd0))
  `SHA_ASSERT_IMP(a_no_byte_in_comp, clk_i, rst_ni, state_q == sha_pkg::StComp, !byte_en)

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the streaming SHA-256 hasher core.
`timescale 1ns / 1ps

// Holds the digest prediction state and the queue of pending digest words.
class digest_scoreboard;
  logic [31:0] chain_q [8];
  logic [7:0]  block_q [64];
  logic [5:0]  fill_q;
  logic [63:0] byte_count_q;
  logic [63:0] pend_word_q [$];
  logic [1:0]  pend_idx_q [$];
  logic        pend_last_q [$];
  int          mismatch_cnt;

  function new();
    mismatch_cnt = 0;
    restart();
  endfunction

  function void restart();
    foreach (chain_q[i]) chain_q[i] = sha_pkg::InitH[i];
    fill_q = '0;
    byte_count_q = '0;
  endfunction

  function logic [31:0] rot_right(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Run the 64 rounds over the buffered block and fold into the chain.
  function void compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_q[4*i], block_q[4*i+1], block_q[4*i+2], block_q[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rot_right(w[i-15], 7) ^ rot_right(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rot_right(w[i-2], 17) ^ rot_right(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    v = chain_q;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[i] + w[i];
      t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] += v[i];
  endfunction

  // Note an accepted input transfer.
  function void note_input(logic op, logic [7:0] data);
    logic [63:0] bits;
    int k;
    if (!op) begin
      block_q[fill_q] = data;
      fill_q++;
      byte_count_q++;
      if (fill_q == 0) compress();
      return;
    end
    bits = byte_count_q << 3;
    k = fill_q;
    block_q[k] = sha_pkg::PadByte;
    k++;
    if (k > sha_pkg::LenPos) begin
      for (int i = k; i < 64; i++) block_q[i] = '0;
      compress();
      k = 0;
    end
    for (int i = k; i < sha_pkg::LenPos; i++) block_q[i] = '0;
    for (int i = 0; i < 8; i++) block_q[63-i] = bits[8*i +: 8];
    compress();
    for (int i = 0; i < 4; i++) begin
      pend_word_q.push_back({chain_q[2*i], chain_q[2*i+1]});
      pend_idx_q.push_back(2'(i));
      pend_last_q.push_back(i == 3);
    end
    restart();
  endfunction

  function void report(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_cnt++;
  endfunction

  // Check one output transfer against the oldest pending word.
  function void check_word(logic [63:0] word, logic [1:0] idx, logic last);
    logic [63:0] ew;
    logic [1:0]  ei;
    logic        el;
    if (pend_word_q.size() == 0) begin
      report($sformatf("unexpected digest word %h", word));
      return;
    end
    ew = pend_word_q.pop_front();
    ei = pend_idx_q.pop_front();
    el = pend_last_q.pop_front();
    if (word !== ew) report($sformatf("digest_word %h, want %h", word, ew));
    if (idx !== ei) report($sformatf("word_index %0d, want %0d", idx, ei));
    if (last !== el) report($sformatf("last_word %0b, want %0b", last, el));
  endfunction
endclass

module testbench;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        op;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  digest_scoreboard sb;
  bit hold_off_req;
  bit sink_quiet;

  sha256_stream_hasher_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .op_i(op), .data_byte_i(data_byte),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .digest_word_o(digest_word), .word_index_o(word_index), .last_word_o(last_word)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 40) return 0;
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one item and hold it until the transfer; valid drops only for a gap.
  task automatic send_item(logic item_op, logic [7:0] item_data, bit gaps);
    int gap;
    gap = gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= item_op;
    data_byte <= item_data;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item_op, item_data);
  endtask

  task automatic send_message(int len, bit gaps);
    for (int i = 0; i < len; i++) send_item(1'b0, 8'($urandom), gaps);
    send_item(1'b1, 8'($urandom), gaps);
  endtask

  // Drop valid and wait until every expected word has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pend_word_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: always ready when quiet, else random stalls, or a long forced hold-off on request.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_word(digest_word, word_index, last_word);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (sink_quiet) begin
        out_ready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus.
  initial begin
    int sent;
    int len;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    op = 1'b0;
    data_byte = '0;
    hold_off_req = 1'b0;
    sink_quiet = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, data ignored on finish, byte extremes, a short message.
    send_item(1'b1, 8'hff, 1'b0);
    send_item(1'b0, 8'h00, 1'b0);
    send_item(1'b0, 8'hff, 1'b0);
    send_item(1'b1, 8'h00, 1'b0);
    send_message(3, 1'b0);
    wait_drained();
    // Boundary lengths: 55, 56 and 64 need no, one and a full extra block.
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    send_message(64, 1'b0);
    send_message(63, 1'b0);
    wait_drained();

    // Long receiver hold-off while messages keep coming.
    hold_off_req = 1'b1;
    sink_quiet = 1'b0;
    send_item(1'b1, 8'h00, 1'b0);
    send_message(2, 1'b0);
    send_message(1, 1'b0);
    wait_drained();

    // Random messages, mostly short, a few long.
    sent = 0;
    while (sent < 100) begin
      if ($urandom_range(0, 9) == 0) len = $urandom_range(57, 130);
      else len = $urandom_range(0, 20);
      send_message(len, 1'b1);
      sent += len + 1;
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (sb.mismatch_cnt == 0 && sb.pend_word_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end
endmodule
